// ===== sv/stfc_pkg.sv =====
// Package for the servo tester frame controller.
// Holds the phase and digit codes, the register indexes, the shared structs and the segment table.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package stfc_pkg;

  // Phase of the tester, also driven out as the phase code.
  typedef enum logic [1:0] {
    PH_GREET = 2'd0,
    PH_ARM   = 2'd1,
    PH_RUN   = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  // Digit codes: 0 to 9 are decimal digits, then letters and blank.
  localparam logic [3:0] CODE_ZERO  = 4'd0;
  localparam logic [3:0] CODE_NINE  = 4'd9;
  localparam logic [3:0] CODE_H     = 4'd10;
  localparam logic [3:0] CODE_I     = 4'd11;
  localparam logic [3:0] CODE_BLANK = 4'd12;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 4;
  localparam logic [CFG_IDX_BITS-1:0] REG_GREET_FRAMES     = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEUTRAL_WIDTH    = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_WRAP       = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_SHOW_ABOVE = 4'd3;
  localparam int unsigned CFG_DATA_BITS = 11;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]  greet_frames;
    logic [10:0] neutral_width_us;
    logic [5:0]  blink_wrap;
    logic [5:0]  blink_show_above;
  } stfc_cfg_t;

  // Result of mapping one pot reading.
  typedef struct packed {
    logic [9:0] mapped_length;
    logic [3:0] tens_code;
    logic [3:0] ones_code;
  } stfc_pot_t;

  // State carried from frame to frame.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] greet_count;
    logic [5:0] blink_count;
    logic [9:0] mapped_length;
    logic [3:0] tens_code;
    logic [3:0] ones_code;
    logic [6:0] last_left;
    logic [6:0] last_right;
  } stfc_state_t;

  // One result item.
  typedef struct packed {
    logic [10:0] pulse_width_us;
    logic [6:0]  left_segments;
    logic [6:0]  right_segments;
    logic        left_enable;
    logic        right_enable;
    logic        negative_dot;
    logic [1:0]  phase_now;
  } stfc_result_t;

  // Seven-segment pattern for a digit code; unused codes are blank.
  function automatic logic [6:0] seg_of(input logic [3:0] code);
    logic [6:0] seg;
    unique case (code)
      4'd0:    seg = 7'd119;
      4'd1:    seg = 7'd36;
      4'd2:    seg = 7'd93;
      4'd3:    seg = 7'd109;
      4'd4:    seg = 7'd46;
      4'd5:    seg = 7'd107;
      4'd6:    seg = 7'd123;
      4'd7:    seg = 7'd37;
      4'd8:    seg = 7'd127;
      4'd9:    seg = 7'd111;
      4'd10:   seg = 7'd62;
      4'd11:   seg = 7'd16;
      default: seg = 7'd0;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== sv/servo_tester_frame_controller.sv =====
// Top level of the servo tester frame controller: stream ports, configuration registers,
// input and result registers, and the frame state. Uses stfc_pkg, stfc_pot_map, stfc_frame_step.
`timescale 1ns / 1ps
`default_nettype none

// One input transfer is one servo frame: a pot sample and the power switch level. Each frame
// gives exactly one result transfer carrying the pulse width, both digit patterns and enables,
// the negative-direction dot and the phase code. An input transfer is registered, then worked
// through the pot mapper and the frame step logic into the result register, and one frame
// is taken every cycle while the result side keeps taking. Configuration writes are taken
// at any time on their own channel and must only be made while no frame is in flight;
// writes to unknown indexes are ignored.
module servo_tester_frame_controller
  import stfc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Input frames.
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // From bit 0: pot_sample (SAMPLE_BITS), power_on (1), zero fill.
  input  wire logic [((SAMPLE_BITS+8)/8)*8-1:0] s_tdata,
  // Result items.
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // From bit 0: pulse_width_us (11), left_segments (7), right_segments (7), left_enable (1),
  // right_enable (1), negative_dot (1), phase_now (2), zero fill.
  output logic [31:0]                   m_tdata,
  // Configuration writes.
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  stfc_cfg_t                cfg;
  stfc_state_t              st;
  stfc_state_t              st_next;
  stfc_pot_t                pot;
  stfc_result_t             res;
  stfc_result_t             out_res;
  logic                     in_valid;
  logic [SAMPLE_BITS-1:0]   in_pot;
  logic                     in_power;
  logic                     out_valid;
  logic                     advance;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.greet_frames     <= 8'd50;
      cfg.neutral_width_us <= 11'd1500;
      cfg.blink_wrap       <= 6'd50;
      cfg.blink_show_above <= 6'd25;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GREET_FRAMES:     cfg.greet_frames     <= cfg_data[7:0];
        REG_NEUTRAL_WIDTH:    cfg.neutral_width_us <= cfg_data[10:0];
        REG_BLINK_WRAP:       cfg.blink_wrap       <= cfg_data[5:0];
        REG_BLINK_SHOW_ABOVE: cfg.blink_show_above <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // The frame moves on when it is registered and the result register is free or being emptied.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pot   <= s_tdata[SAMPLE_BITS-1:0];
      in_power <= s_tdata[SAMPLE_BITS];
    end
  end

  stfc_pot_map #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_pot_map (
    .pot_sample(in_pot),
    .pot       (pot)
  );

  stfc_frame_step u_frame_step (
    .st      (st),
    .cfg     (cfg),
    .pot     (pot),
    .power_on(in_power),
    .st_next (st_next),
    .res     (res)
  );

  // Frame state, updated as each frame passes to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_GREET;
      st.greet_count   <= 8'd0;
      st.blink_count   <= 6'd0;
      st.mapped_length <= 10'd1000;
      st.tens_code     <= CODE_H;
      st.ones_code     <= CODE_I;
      st.last_left     <= 7'd0;
      st.last_right    <= 7'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.phase_now, out_res.negative_dot, out_res.right_enable,
                     out_res.left_enable, out_res.right_segments, out_res.left_segments,
                     out_res.pulse_width_us};

  // A frame with power off must leave the frame state untouched.
  a_power_off_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_power) |=> (st == $past(st)))
    else $error("frame state changed on a power-off frame");

  // Input side stalls only while both registers are full and the result is not taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a full pipeline");

  // Running is never left once reached.
  a_run_sticks: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_RUN) |=> (st.phase == PH_RUN))
    else $error("phase left running");

endmodule

`default_nettype wire

// ===== sv/stfc_pot_map.sv =====
// Pot reading mapper: normalises the sample, applies the centre dead zone and splits the
// deflection into percent digits. Uses stfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stfc_pot_map
  import stfc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic [SAMPLE_BITS-1:0] pot_sample,
  output stfc_pot_t                   pot
);

  logic [9:0]  x;
  logic [9:0]  xs;
  logic        above_mid;
  logic [9:0]  mapped;
  logic [8:0]  dev;
  logic [16:0] dev_by5;
  logic [14:0] dev_by50;
  logic [6:0]  quot5;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones_wide;

  // Bring the sample to ten bits.
  generate
    if (SAMPLE_BITS >= 10) begin : g_shift_down
      assign x = pot_sample[SAMPLE_BITS-1 -: 10];
    end else begin : g_shift_up
      assign x = {pot_sample, {(10-SAMPLE_BITS){1'b0}}};
    end
  endgenerate

  // Dead zone around centre folds onto the first value above it.
  assign xs        = (x >= 10'd500 && x < 10'd524) ? 10'd524 : x;
  assign above_mid = xs > 10'd512;
  assign mapped    = above_mid ? (xs - 10'd24) : xs;
  assign dev       = above_mid ? 9'(mapped - 10'd500) : 9'(10'd500 - xs);

  // Divisions by 5 and 50 by reciprocal multiplication, exact for deviations up to 500.
  assign dev_by5   = 17'(dev) * 17'd205;
  assign dev_by50  = 15'(dev) * 15'd41;
  assign quot5     = dev_by5[16:10];
  assign tens      = dev_by50[14:11];
  assign tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
  assign ones_wide = quot5 - tens_x10;

  // Full deflection reads as 99.
  always_comb begin
    pot.mapped_length = mapped;
    if (tens >= 4'd10) begin
      pot.tens_code = CODE_NINE;
      pot.ones_code = CODE_NINE;
    end else begin
      pot.tens_code = tens;
      pot.ones_code = ones_wide[3:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/stfc_frame_step.sv =====
// Frame step logic: next phase and counters, and the result item for one frame.
// Uses stfc_pkg and the mapped pot reading from stfc_pot_map.
`timescale 1ns / 1ps
`default_nettype none

module stfc_frame_step
  import stfc_pkg::*;
(
  input  wire stfc_state_t st,
  input  wire stfc_cfg_t   cfg,
  input  wire stfc_pot_t   pot,
  input  wire logic        power_on,
  output stfc_state_t      st_next,
  output stfc_result_t     res
);

  logic [7:0] greet_inc;
  logic [5:0] blink_inc;
  logic [5:0] blink_new;
  logic [6:0] seg_tens;
  logic [6:0] seg_ones;
  logic       near_centre;

  assign greet_inc   = st.greet_count + 8'd1;
  assign blink_inc   = st.blink_count + 6'd1;
  assign blink_new   = (blink_inc > cfg.blink_wrap) ? 6'd0 : blink_inc;
  assign seg_tens    = seg_of(st.tens_code);
  assign seg_ones    = seg_of(st.ones_code);
  assign near_centre = (pot.mapped_length > 10'd495) && (pot.mapped_length < 10'd505);

  // Next phase and state; a frame with power off leaves everything as it is.
  always_comb begin
    st_next = st;
    if (power_on) begin
      unique case (st.phase)
        PH_GREET: begin
          st_next.greet_count = greet_inc;
          st_next.last_left   = seg_tens;
          st_next.last_right  = seg_ones;
          if (greet_inc >= cfg.greet_frames) begin
            st_next.phase = PH_ARM;
          end
        end
        PH_ARM: begin
          st_next.blink_count   = blink_new;
          st_next.last_right    = seg_ones;
          st_next.mapped_length = pot.mapped_length;
          st_next.tens_code     = pot.tens_code;
          st_next.ones_code     = (blink_new > cfg.blink_show_above) ? CODE_ZERO : CODE_BLANK;
          if (near_centre) begin
            st_next.phase = PH_RUN;
          end
        end
        PH_RUN: begin
          st_next.last_left     = seg_tens;
          st_next.last_right    = seg_ones;
          st_next.mapped_length = pot.mapped_length;
          st_next.tens_code     = pot.tens_code;
          st_next.ones_code     = pot.ones_code;
        end
        PH_OFF: begin
          st_next = st;
        end
      endcase
    end
  end

  // Result item, taken from the state held before this frame's reading.
  always_comb begin
    res.pulse_width_us = cfg.neutral_width_us;
    res.left_segments  = seg_tens;
    res.right_segments = seg_ones;
    res.left_enable    = 1'b1;
    res.right_enable   = 1'b1;
    res.negative_dot   = st.mapped_length <= 10'd495;
    res.phase_now      = st.phase;
    if (!power_on) begin
      res.left_segments  = 7'd0;
      res.right_segments = 7'd0;
      res.left_enable    = 1'b0;
      res.right_enable   = 1'b0;
      res.negative_dot   = 1'b0;
      res.phase_now      = PH_OFF;
    end else begin
      unique case (st.phase)
        PH_GREET: begin
          res.phase_now = PH_GREET;
        end
        PH_ARM: begin
          res.left_segments = st.last_left;
          res.left_enable   = 1'b0;
        end
        PH_RUN: begin
          res.pulse_width_us = 11'({1'b0, st.mapped_length} + 11'd1000);
        end
        PH_OFF: begin
          res.phase_now = PH_OFF;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
